/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/ufdr_pkg.sv */
// ----------------------------------------------------------------------------
// ufdr_pkg
// Types, codes and defaults shared by the UART frame deframer ring.
// ----------------------------------------------------------------------------
package ufdr_pkg;

  // Default sizes of the frame store.
  localparam int unsigned FrameBytesDef = 2048;
  localparam int unsigned RingSlotsDef  = 8;

  // Fixed field widths.
  localparam int unsigned ReqW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RdOffW  = 11;
  localparam int unsigned OutLenW = 12;
  localparam int unsigned EventW  = 3;
  localparam int unsigned PosW    = 12;
  localparam int unsigned IdleW   = 17;
  localparam int unsigned TmoW    = 16;

  // Configuration port.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Request codes.
  localparam logic [ReqW-1:0] ReqByte    = 2'd0;
  localparam logic [ReqW-1:0] ReqTick    = 2'd1;
  localparam logic [ReqW-1:0] ReqRead    = 2'd2;
  localparam logic [ReqW-1:0] ReqRelease = 2'd3;

  // Event codes.
  localparam logic [EventW-1:0] EvNone    = 3'd0;
  localparam logic [EventW-1:0] EvStored  = 3'd1;
  localparam logic [EventW-1:0] EvFull    = 3'd2;
  localparam logic [EventW-1:0] EvBadLen  = 3'd3;
  localparam logic [EventW-1:0] EvBadEnd  = 3'd4;
  localparam logic [EventW-1:0] EvTimeout = 3'd5;

  // Framing bytes.
  localparam logic [ByteW-1:0] StartByte = 8'hAA;
  localparam logic [ByteW-1:0] EndByte   = 8'h55;

  // Register index of the idle timeout.
  localparam logic RegIdleTimeout = 1'b0;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [ByteW-1:0]  rx_byte;
    logic [RdOffW-1:0] read_offset;
  } in_beat_t;

  typedef struct packed {
    logic               frame_available;
    logic [OutLenW-1:0] oldest_length;
    logic [ByteW-1:0]   read_data;
    logic [EventW-1:0]  event_code;
  } out_beat_t;

endpackage

/* hdl/uart_frame_deframer_ring_unit.sv */
// ----------------------------------------------------------------------------
// uart_frame_deframer_ring_unit
// Pipeline: two register stages; a taken request beat waits in stage one for
// its memory read, then moves to stage two, the output register.
// Throughput: one beat per cycle unless the result side stalls; the single-port
// payload memory serves the write or read that a beat may need in its accept cycle.
// Reset clears the parser, the ring pointers, the idle counter and the timeout
// register at once; the payload and length stores are not cleared, so the
// block accepts beats right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_frame_deframer_ring_unit
  import ufdr_pkg::*;
#(
  parameter int unsigned FrameBytes = FrameBytesDef,
  parameter int unsigned RingSlots  = RingSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  // Payload memory holds one slot of FrameBytes bytes per ring entry.
  localparam int unsigned MemDepth = FrameBytes * RingSlots;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned SlotW    = (RingSlots > 1) ? $clog2(RingSlots) : 1;
  // Stored lengths range from zero to FrameBytes inclusive.
  localparam int unsigned LenW     = $clog2(FrameBytes + 1);
  localparam int unsigned CmpW     = (LenW > RdOffW) ? LenW : RdOffW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RingSlots - 1);
  localparam logic [IdleW-1:0] IdleMax  = {IdleW{1'b1}};

  // Parser phases.
  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhLenLo = 3'd1;
  localparam logic [2:0] PhLenHi = 3'd2;
  localparam logic [2:0] PhSkipA = 3'd3;
  localparam logic [2:0] PhSkipB = 3'd4;
  localparam logic [2:0] PhBody  = 3'd5;
  localparam logic [2:0] PhEndA  = 3'd6;
  localparam logic [2:0] PhEndB  = 3'd7;

  // The result of a beat, waiting for the memory read data to join it.
  typedef struct packed {
    logic               frame_available;
    logic [OutLenW-1:0] oldest_length;
    logic [EventW-1:0]  event_code;
    logic               rd_hit;
  } stage_t;

  // --------------------------------------------------------------------------
  // Configuration register. Only the idle timeout exists; a write to any other
  // word is ignored and a read of it returns zero.
  // --------------------------------------------------------------------------
  logic [TmoW-1:0] timeout_q;
  logic            cfg_we;
  logic            cfg_sel0;

  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[2] == RegIdleTimeout);
  assign cfg_we   = psel && penable && pwrite && pready && cfg_sel0;
  assign prdata   = cfg_sel0 ? PdataW'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
    end else if (cfg_we) begin
      timeout_q <= pwdata[TmoW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage one holds a beat whose memory read is in flight; stage
  // two is the output register. The request side only stalls when both are
  // full and the result side stalls, so beats flow one per cycle otherwise.
  // --------------------------------------------------------------------------
  logic      s1_v_q, s2_v_q;
  stage_t    s1_q, s1_d;
  out_beat_t s2_q;
  logic      s1_adv;
  logic      in_acc;

  assign s1_adv     = s1_v_q && (!s2_v_q || !out_stall_i);
  assign in_stall_o = s1_v_q && s2_v_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Parser and ring state.
  // --------------------------------------------------------------------------
  logic [2:0]       phase_q, phase_d;
  logic [1:0]       run_q, run_d;
  logic [ByteW-1:0] len_lo_q, len_lo_d;
  logic [LenW-1:0]  flen_q, flen_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [IdleW-1:0] idle_q, idle_d;
  logic [SlotW-1:0] head_q, head_d, tail_q, tail_d;

  // Length store, one entry per slot, written when a frame commits.
  logic [LenW-1:0]  len_mem_q [RingSlots];
  logic             len_we;

  // Payload memory port.
  logic [ByteW-1:0] mem_q [MemDepth];
  logic [ByteW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;

  // Helper values.
  logic [15:0]      len_full;
  logic [SlotW-1:0] head_nx, tail_nx;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [LenW-1:0]  len_sel;
  logic             rd_ok;

  assign len_full = {in_beat_i.rx_byte, len_lo_q};
  assign head_nx  = (head_q == LastSlot) ? '0 : head_q + SlotW'(1);
  assign tail_nx  = (tail_q == LastSlot) ? '0 : tail_q + SlotW'(1);
  assign wr_addr  = AddrW'(head_q) * AddrW'(FrameBytes) + AddrW'(pos_q);
  assign rd_addr  = AddrW'(tail_q) * AddrW'(FrameBytes) + AddrW'(in_beat_i.read_offset);

  // A read hits when a frame waits and the offset lies inside both the stored
  // length and the slot.
  assign rd_ok = (head_q != tail_q)
              && (CmpW'(in_beat_i.read_offset) < CmpW'(len_mem_q[tail_q]))
              && (CmpW'(in_beat_i.read_offset) < CmpW'(FrameBytes));

  always_comb begin
    phase_d  = phase_q;
    run_d    = run_q;
    len_lo_d = len_lo_q;
    flen_d   = flen_q;
    pos_d    = pos_q;
    idle_d   = idle_q;
    head_d   = head_q;
    tail_d   = tail_q;
    len_we   = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = wr_addr;
    s1_d     = '0;

    if (in_acc) begin
      unique case (in_beat_i.req_type)
        ReqByte: begin
          idle_d = '0;
          unique case (phase_q)
            PhHunt: begin
              if (in_beat_i.rx_byte == StartByte) begin
                run_d = run_q + 2'd1;
                if (run_q == 2'd3) begin
                  phase_d = PhLenLo;
                end
              end else begin
                run_d = '0;
              end
            end
            PhLenLo: begin
              len_lo_d = in_beat_i.rx_byte;
              phase_d  = PhLenHi;
            end
            PhLenHi: begin
              if (32'(len_full) > FrameBytes) begin
                phase_d         = PhHunt;
                run_d           = '0;
                pos_d           = '0;
                s1_d.event_code = EvBadLen;
              end else begin
                flen_d  = LenW'(len_full);
                phase_d = PhSkipA;
              end
            end
            PhSkipA: begin
              phase_d = PhSkipB;
            end
            PhSkipB: begin
              pos_d   = '0;
              phase_d = PhBody;
            end
            PhBody: begin
              // A zero length still takes one byte before the end bytes.
              mem_we = (32'(pos_q) < FrameBytes);
              pos_d  = pos_q + PosW'(1);
              if ((PosW + 1)'(pos_d) >= (PosW + 1)'(flen_q)) begin
                phase_d = PhEndA;
              end
            end
            PhEndA: begin
              if (in_beat_i.rx_byte == EndByte) begin
                phase_d = PhEndB;
              end else begin
                phase_d         = PhHunt;
                run_d           = '0;
                pos_d           = '0;
                s1_d.event_code = EvBadEnd;
              end
            end
            PhEndB: begin
              phase_d = PhHunt;
              if (in_beat_i.rx_byte != EndByte) begin
                s1_d.event_code = EvBadEnd;
              end else if (head_nx == tail_q) begin
                s1_d.event_code = EvFull;
              end else begin
                len_we          = 1'b1;
                head_d          = head_nx;
                s1_d.event_code = EvStored;
              end
            end
            default: begin
              phase_d = PhHunt;
            end
          endcase
        end
        ReqTick: begin
          if (idle_q != IdleMax) begin
            idle_d = idle_q + IdleW'(1);
          end
          if ((phase_q != PhHunt) && (timeout_q != '0)
              && (idle_d > IdleW'(timeout_q))) begin
            phase_d         = PhHunt;
            run_d           = '0;
            pos_d           = '0;
            s1_d.event_code = EvTimeout;
          end
        end
        ReqRead: begin
          mem_re      = 1'b1;
          mem_addr    = rd_addr;
          s1_d.rd_hit = rd_ok;
        end
        ReqRelease: begin
          if (head_q != tail_q) begin
            tail_d = tail_nx;
          end
        end
        default: begin
          idle_d = idle_q;
        end
      endcase
    end

    // The result shows the ring after the beat. A commit into an empty ring
    // makes the new entry the oldest, so its length is forwarded.
    len_sel = (len_we && (tail_d == head_q)) ? flen_q : len_mem_q[tail_d];
    s1_d.frame_available = (head_d != tail_d);
    s1_d.oldest_length   = s1_d.frame_available ? OutLenW'(len_sel) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      run_q   <= '0;
      flen_q  <= '0;
      pos_q   <= '0;
      idle_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      flen_q  <= flen_d;
      pos_q   <= pos_d;
      idle_q  <= idle_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q <= len_lo_d;
    if (len_we) begin
      len_mem_q[head_q] <= flen_q;
    end
  end

  // Single-port payload memory with registered read data. The read register
  // only loads on an accepted read, so it holds while stage one is stalled.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= in_beat_i.rx_byte;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result pipeline.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc || (s1_v_q && !s1_adv);
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_v_q && !out_stall_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      s2_q.frame_available <= s1_q.frame_available;
      s2_q.oldest_length   <= s1_q.oldest_length;
      s2_q.read_data       <= s1_q.rd_hit ? rdata_q : '0;
      s2_q.event_code      <= s1_q.event_code;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_beat_o  = s2_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_stall_needs_full, !in_stall_o || (s1_v_q && s2_v_q), "stall with free stage")
  `ASSERT_CLK(a_stored_shows_frame,
              !(s1_v_q && (s1_q.event_code == EvStored)) || s1_q.frame_available,
              "stored frame not reported as available")
  `ASSERT_CLK(a_body_pos_bound,
              (phase_q != PhBody) || ((PosW + 1)'(pos_q) <= (PosW + 1)'(flen_q)),
              "payload position beyond frame length")
  `ASSERT_NEXT(a_body_exit,
               in_acc && (in_beat_i.req_type == ReqByte) && (phase_q == PhBody),
               (phase_q == PhBody) || (phase_q == PhEndA),
               "body byte left to a wrong phase")

endmodule

/* bench/tb_uart_frame_deframer_ring_unit.sv */
// ----------------------------------------------------------------------------
// tb_uart_frame_deframer_ring_unit
// Self-checking bench for the UART deframer and its frame ring. Request beats
// (bytes, ticks, reads and releases) are driven with random gaps in most phases.
// Each accepted beat is run through a behavioral copy of the parser and the ring,
// and every result beat is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_uart_frame_deframer_ring_unit;
  import ufdr_pkg::*;

  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned WatchdogCycles = 1_000_000;

  // Parser phases, in the order a well-formed frame walks through them.
  typedef enum logic [2:0] {
    PhHunt, PhLenLo, PhLenHi, PhSkipA, PhSkipB, PhBody, PhEndA, PhEndB
  } parse_phase_e;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the parser, the ring and the timeout
  // register, works out the result of every accepted request beat, and checks
  // the result beats in order.
  // --------------------------------------------------------------------------
  class frame_ring_scoreboard;
    out_beat_t          expected_beats[$];
    logic [ByteW-1:0]   payload_mem [FrameBytesDef*RingSlotsDef];
    logic [OutLenW-1:0] slot_len [RingSlotsDef];
    int unsigned        head;
    int unsigned        tail;
    parse_phase_e       phase;
    logic [1:0]         start_run;
    logic [15:0]        frame_len;
    logic [PosW-1:0]    body_pos;
    logic [IdleW-1:0]   idle_ms;
    logic [TmoW-1:0]    idle_limit;
    int unsigned        errors;
    int unsigned        beats_seen;
    int unsigned        event_tally [8];

    function new();
      foreach (payload_mem[i]) payload_mem[i] = '0;
      foreach (slot_len[i]) slot_len[i] = '0;
      foreach (event_tally[i]) event_tally[i] = 0;
      head       = 0;
      tail       = 0;
      phase      = PhHunt;
      start_run  = '0;
      frame_len  = '0;
      body_pos   = '0;
      idle_ms    = '0;
      idle_limit = '0;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void set_timeout(logic [TmoW-1:0] value);
      idle_limit = value;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function int unsigned next_slot(int unsigned slot);
      return (slot + 1 == RingSlotsDef) ? 0 : slot + 1;
    endfunction

    function void abandon_frame();
      phase     = PhHunt;
      start_run = '0;
      body_pos  = '0;
    endfunction

    // Advances the behavioral state by one accepted request beat and queues
    // the result beat that it must produce.
    function void note_request(in_beat_t beat);
      out_beat_t         exp;
      logic [EventW-1:0] ev;
      int unsigned       nxt;
      exp = '0;
      ev  = EvNone;
      case (beat.req_type)
        ReqByte: begin
          idle_ms = '0;
          case (phase)
            PhHunt: begin
              if (beat.rx_byte == StartByte) begin
                start_run = start_run + 2'd1;
                if (start_run == 2'd0) phase = PhLenLo;
              end else begin
                start_run = '0;
              end
            end
            PhLenLo: begin
              frame_len = {8'h00, beat.rx_byte};
              phase     = PhLenHi;
            end
            PhLenHi: begin
              frame_len[15:8] = beat.rx_byte;
              if (frame_len > 16'(FrameBytesDef)) begin
                abandon_frame();
                ev = EvBadLen;
              end else begin
                phase = PhSkipA;
              end
            end
            PhSkipA: phase = PhSkipB;
            PhSkipB: begin
              body_pos = '0;
              phase    = PhBody;
            end
            PhBody: begin
              if (body_pos < PosW'(FrameBytesDef))
                payload_mem[head*FrameBytesDef + body_pos] = beat.rx_byte;
              body_pos = body_pos + 1'b1;
              // A zero length still takes one body byte before the end bytes.
              if ({4'h0, body_pos} >= frame_len) phase = PhEndA;
            end
            PhEndA: begin
              if (beat.rx_byte == EndByte) begin
                phase = PhEndB;
              end else begin
                abandon_frame();
                ev = EvBadEnd;
              end
            end
            default: begin
              if (beat.rx_byte == EndByte) begin
                nxt = next_slot(head);
                if (nxt == tail) begin
                  ev = EvFull;
                end else begin
                  slot_len[head] = frame_len[OutLenW-1:0];
                  head = nxt;
                  ev   = EvStored;
                end
              end else begin
                ev = EvBadEnd;
              end
              phase = PhHunt;
            end
          endcase
        end
        ReqTick: begin
          if (idle_ms != '1) idle_ms = idle_ms + 1'b1;
          if (phase != PhHunt && idle_limit != '0 && idle_ms > {1'b0, idle_limit}) begin
            abandon_frame();
            ev = EvTimeout;
          end
        end
        ReqRead: begin
          if (head != tail && {1'b0, beat.read_offset} < slot_len[tail])
            exp.read_data = payload_mem[tail*FrameBytesDef + beat.read_offset];
        end
        default: begin
          if (head != tail) tail = next_slot(tail);
        end
      endcase
      exp.frame_available = (head != tail);
      exp.oldest_length   = (head != tail) ? slot_len[tail] : '0;
      exp.event_code      = ev;
      event_tally[ev]++;
      beats_seen++;
      expected_beats.push_back(exp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat %h arrived with nothing expected, expected none, actual %h",
                 $time, got, got);
        return;
      end
      exp = expected_beats.pop_front();
      compare_field("frame_available", 16'(exp.frame_available), 16'(got.frame_available));
      compare_field("oldest_length", 16'(exp.oldest_length), 16'(got.oldest_length));
      compare_field("read_data", 16'(exp.read_data), 16'(got.read_data));
      compare_field("event_code", 16'(exp.event_code), 16'(got.event_code));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts from a known value.
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_beat_t          in_beat_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_beat_t         out_beat_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [PdataW-1:0] pwdata      = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  frame_ring_scoreboard sb;
  in_beat_t             stim_q[$];
  bit                   send_gaps;
  bit                   recv_gaps;
  int unsigned          rx_hold;
  int unsigned          cfg_errors;

  uart_frame_deframer_ring_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #(ClkPeriod/2);
    clk_i = 1'b0;
    #(ClkPeriod/2);
  end

  // Hard stop in case the block stops producing beats or stops taking them.
  initial begin
    #(WatchdogCycles * ClkPeriod);
    $display("Watchdog expired with %0d result beats outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side. A pending hold-off keeps stall high until it has counted down, so
  // the block backs up; otherwise stall is raised at random when enabled.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall_i <= recv_gaps && ($urandom_range(99) < 16);
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the block
  // updates them, so the order of processes within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
  end

  // --------------------------------------------------------------------------
  // Stimulus building. Fields that a request ignores still get random values
  // so every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic void add_req(logic [ReqW-1:0] req, logic [ByteW-1:0] b,
                                  logic [RdOffW-1:0] off);
    in_beat_t t;
    t.req_type    = req;
    t.rx_byte     = b;
    t.read_offset = off;
    stim_q.push_back(t);
  endfunction

  function automatic void add_byte(logic [ByteW-1:0] b);
    add_req(ReqByte, b, RdOffW'($urandom));
  endfunction

  function automatic void add_ticks(int unsigned n);
    repeat (n) add_req(ReqTick, ByteW'($urandom), RdOffW'($urandom));
  endfunction

  function automatic void add_release();
    add_req(ReqRelease, ByteW'($urandom), RdOffW'($urandom));
  endfunction

  function automatic void add_read(logic [RdOffW-1:0] off);
    add_req(ReqRead, ByteW'($urandom), off);
  endfunction

  function automatic logic [ByteW-1:0] not_end_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom);
    return (b == EndByte) ? 8'h00 : b;
  endfunction

  // Mostly short frames, a few medium ones, rarely a long one.
  function automatic int unsigned pick_len();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 75) return $urandom_range(12);
    if (k < 95) return $urandom_range(64, 13);
    return $urandom_range(300, 65);
  endfunction

  // Builds a frame: four start bytes, the length low byte first, two reserved
  // bytes, the body and the two end bytes. Ticks may be slipped in between
  // bytes so the idle timeout gets a chance to fire mid-frame. With
  // header_only set the frame stops right after the length.
  function automatic void add_frame(int unsigned len, logic [ByteW-1:0] end_a,
                                    logic [ByteW-1:0] end_b, int unsigned tick_pct,
                                    bit header_only = 1'b0);
    logic [ByteW-1:0] bytes[$];
    int unsigned      body;
    body = (len == 0) ? 1 : len;
    repeat (4) bytes.push_back(StartByte);
    bytes.push_back(ByteW'(len));
    bytes.push_back(ByteW'(len >> 8));
    if (!header_only) begin
      repeat (2) bytes.push_back(ByteW'($urandom));
      repeat (body) bytes.push_back(ByteW'($urandom));
      bytes.push_back(end_a);
      bytes.push_back(end_b);
    end
    foreach (bytes[i]) begin
      if (i > 0 && tick_pct > 0 && $urandom_range(99) < tick_pct)
        add_ticks($urandom_range(4, 1));
      add_byte(bytes[i]);
    end
  endfunction

  // Random traffic: mostly well-formed frames with random content, the rest
  // broken frames, reads, releases, tick bursts and line noise.
  function automatic void add_mix(int unsigned n, int unsigned rel_pct,
                                  int unsigned tick_pct);
    int unsigned r;
    int unsigned k;
    int unsigned target;
    target = stim_q.size() + n;
    while (stim_q.size() < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        add_frame(pick_len(), EndByte, EndByte, tick_pct);
      end else if (r < 65) begin
        k = $urandom_range(3);
        case (k)
          0: add_frame($urandom_range(65535, FrameBytesDef + 1), EndByte, EndByte, 0, 1'b1);
          1: add_frame(pick_len(), not_end_byte(), ByteW'($urandom), tick_pct);
          2: add_frame(pick_len(), EndByte, not_end_byte(), tick_pct);
          default: begin
            // A short run of start bytes cut off by something else.
            repeat ($urandom_range(3, 1)) add_byte(StartByte);
            add_byte(8'h00);
          end
        endcase
      end else if (r < 77) begin
        k = $urandom_range(99);
        if (k < 60) add_read(RdOffW'($urandom_range(15)));
        else if (k < 80) add_read(RdOffW'($urandom_range(300)));
        else add_read(RdOffW'($urandom));
      end else if (r < 77 + rel_pct) begin
        add_release();
      end else if (r < 92) begin
        add_ticks($urandom_range(5, 1));
      end else begin
        repeat ($urandom_range(3, 1)) add_byte(ByteW'($urandom));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; a beat counts as accepted at
  // the rising edge where valid is high and stall is low.
  // --------------------------------------------------------------------------
  task automatic push_beat(input in_beat_t beat);
    while (send_gaps && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(beat);
    @(negedge clk_i);
  endtask

  // Writes the idle timeout register, then reads it back.
  task automatic cfg_write(input logic [TmoW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {RegIdleTimeout, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_timeout(value);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0000, value}) begin
      cfg_errors++;
      $display("%0t: timeout readback mismatch, expected %0h, actual %0h",
               $time, {16'h0000, value}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sets the timeout while the block is idle, sends the queued beats and
  // waits until every result of the phase has been checked.
  task automatic run_phase(input logic [TmoW-1:0] tmo, input bit gaps,
                           input int unsigned hold);
    cfg_write(tmo);
    send_gaps = gaps;
    recv_gaps = gaps;
    rx_hold   = hold;
    while (stim_q.size() != 0) push_beat(stim_q.pop_front());
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb         = new();
    send_gaps  = 1'b0;
    recv_gaps  = 1'b0;
    rx_hold    = 0;
    cfg_errors = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, timeout of one tick. First a zero-length frame: a
    // single tick inside it stays within the timeout, and the reserved and
    // body bytes use the extreme byte values.
    repeat (4) add_byte(StartByte);
    add_byte(8'h00);
    add_ticks(1);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(EndByte);
    add_byte(EndByte);
    // Reads of the zero-length frame return nothing, at both ends of the
    // offset range. The second release and the last read find the ring empty.
    add_read(RdOffW'(0));
    add_read(RdOffW'(FrameBytesDef - 1));
    add_release();
    add_release();
    add_read(RdOffW'(5));
    // The largest length the field can carry is rejected.
    add_frame(16'hFFFF, EndByte, EndByte, 0, 1'b1);
    // Two ticks of silence after the length low byte abandon the frame.
    repeat (4) add_byte(StartByte);
    add_byte(8'h03);
    add_ticks(2);
    run_phase(16'd1, 1'b1, 0);

    // Largest timeout, few releases so the ring fills and frames get dropped.
    // The receiver holds off for a long stretch at the start so the block
    // backs up and stalls its input.
    add_mix(350, 3, 5);
    run_phase(16'hFFFF, 1'b1, 400);

    // Timeout disabled, no idling on either side for the whole phase.
    add_mix(300, 12, 5);
    run_phase(16'd0, 1'b0, 0);

    // Short timeout with frequent tick bursts inside frames.
    add_mix(300, 8, 15);
    run_phase(16'd3, 1'b1, 0);

    // Longer frames: empty the ring, store one of 64 bytes, read its last
    // byte and the first offset past it, then let a second one fail on its
    // last end byte and check that the stored frame is untouched. A length
    // one past the limit is rejected.
    repeat (RingSlotsDef) add_release();
    add_frame(64, EndByte, EndByte, 0);
    add_read(RdOffW'(63));
    add_read(RdOffW'(64));
    add_read(RdOffW'(0));
    add_read(RdOffW'($urandom));
    add_frame(64, EndByte, not_end_byte(), 0);
    add_read(RdOffW'(63));
    add_release();
    add_frame(FrameBytesDef + 1, EndByte, EndByte, 0, 1'b1);
    add_frame(1, EndByte, EndByte, 0);
    add_read(RdOffW'(0));
    add_mix(100, 8, 5);
    run_phase(16'h8000, 1'b1, 0);

    $display("Checked %0d request beats under five timeout settings and a long receiver",
             sb.beats_seen);
    $display("hold-off: %0d stored, %0d dropped full, %0d bad length, %0d bad end, %0d timeouts.",
             sb.event_tally[EvStored], sb.event_tally[EvFull], sb.event_tally[EvBadLen],
             sb.event_tally[EvBadEnd], sb.event_tally[EvTimeout]);
    if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
